// ----- hw/rtl/htbd_pkg.sv -----
// Shared types and codes for the code tree build and decode block.
// No dependencies; imported by huffman_tree_build_and_decode.
package htbd_pkg;

  // Request kind carried on in_tuser
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DECODE = 1'b1;

  // Fixed field widths of the streaming payload
  localparam int SYMBOL_IN_W  = 8;
  localparam int CODE_WORD_W  = 16;
  localparam int CODE_LEN_W   = 5;
  localparam int SYMBOL_OUT_W = 8;

  // Result status carried on out_tuser
  typedef enum logic [1:0] {
    ST_DECODED  = 2'd0,
    ST_INSERTED = 2'd1,
    ST_FULL     = 2'd2,
    ST_MISSING  = 2'd3
  } status_t;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EVAL = 6'b000010,
    S_RD   = 6'b000100,
    S_LINK = 6'b001000,
    S_DRD  = 6'b010000,
    S_RES  = 6'b100000
  } state_t;

endpackage

// ----- hw/rtl/huffman_tree_build_and_decode.sv -----
// Code tree builder and bit-serial decoder: node memory plus walk sequencer.
// Depends on htbd_pkg for status codes, request kinds and state encoding.
//
// Usage:
//   The in_ channel takes one request per transfer. in_tuser selects insert or
//   decode. An insert walks the tree from the root along code_len code bits
//   (most significant first), allocates and clears missing nodes, and marks
//   the final node as a leaf holding the symbol; it always answers with status
//   inserted or store full and returns the decode walker to the root. A decode
//   moves the walker by one code bit and answers only when it lands on a leaf
//   (status decoded) or finds no branch (status missing branch).
//   Each tree level costs one node memory read (registered read data) or one
//   allocation plus parent link write, through the single write port of the
//   node memory.
//   The block takes one request at a time; in_tready is high only between
//   requests. Results go to an output register, so the next request is taken
//   while a result waits. If that register is still full when a new result is
//   ready, the sequencer holds the result until out_tready frees the register.
//   Reset empties the tree (root without children), rewinds the walker to the
//   root and drops any pending result. No memory clearing pass is needed.
module huffman_tree_build_and_decode
  import htbd_pkg::*;
#(
  parameter int NODE_COUNT    = 512,
  parameter int MAX_CODE_BITS = 16,
  parameter int SYMBOL_BITS   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [0] code_bit, [8:1] symbol_in, [24:9] code_word, [29:25] code_len,
  //           [31:30] zero
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  // in_tuser: [0] req_type
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata: [7:0] symbol_out
  output logic [7:0]  out_tdata,
  // out_tuser: [1:0] status
  output logic [1:0]  out_tuser
);

  localparam int IDX_W  = $clog2(NODE_COUNT);
  localparam int USED_W = $clog2(NODE_COUNT + 1);
  localparam int LEN_W  = $clog2(MAX_CODE_BITS + 1);
  localparam int ENT_W  = 2 * IDX_W + 1 + SYMBOL_BITS;
  localparam int LEAF_B = 2 * IDX_W;

  // Input field unpack
  logic                   in_req;
  logic                   in_code_bit;
  logic [SYMBOL_IN_W-1:0] in_symbol;
  logic [CODE_WORD_W-1:0] in_code_word;
  logic [CODE_LEN_W-1:0]  in_code_len;

  assign in_req       = in_tuser[0];
  assign in_code_bit  = in_tdata[0];
  assign in_symbol    = in_tdata[8:1];
  assign in_code_word = in_tdata[24:9];
  assign in_code_len  = in_tdata[29:25];

  // Node memory and its ports
  logic [ENT_W-1:0] mem [NODE_COUNT];
  logic [ENT_W-1:0] rd_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [ENT_W-1:0] mem_wdata;
  logic [IDX_W-1:0] mem_raddr;

  // Read data fields
  logic [IDX_W-1:0]       rd_k0;
  logic [IDX_W-1:0]       rd_k1;
  logic                   rd_leaf;
  logic [SYMBOL_BITS-1:0] rd_sym;

  assign rd_k0   = rd_q[IDX_W-1:0];
  assign rd_k1   = rd_q[2*IDX_W-1:IDX_W];
  assign rd_leaf = rd_q[LEAF_B];
  assign rd_sym  = rd_q[ENT_W-1:LEAF_B+1];

  // Control state
  state_t               state_r, state_nxt;
  logic [USED_W-1:0]    used_r, used_nxt;
  logic [IDX_W-1:0]     walker_r, walker_nxt;
  logic [IDX_W-1:0]     root0_r, root0_nxt;
  logic [IDX_W-1:0]     root1_r, root1_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Working payload
  logic [IDX_W-1:0]         cur_r, cur_nxt;
  logic [IDX_W-1:0]         ent_k0_r, ent_k0_nxt;
  logic [IDX_W-1:0]         ent_k1_r, ent_k1_nxt;
  logic                     ent_leaf_r, ent_leaf_nxt;
  logic [SYMBOL_BITS-1:0]   ent_sym_r, ent_sym_nxt;
  logic [LEN_W-1:0]         len_r, len_nxt;
  logic [MAX_CODE_BITS-1:0] word_r, word_nxt;
  logic [SYMBOL_BITS-1:0]   sym_in_r, sym_in_nxt;
  logic                     dir_r, dir_nxt;
  logic [IDX_W-1:0]         new_r, new_nxt;
  logic [IDX_W-1:0]         wk0_r, wk0_nxt;
  logic [IDX_W-1:0]         wk1_r, wk1_nxt;
  logic [SYMBOL_OUT_W-1:0]  res_sym_r, res_sym_nxt;
  status_t                  res_st_r, res_st_nxt;
  logic [SYMBOL_OUT_W-1:0]  out_sym_r, out_sym_nxt;
  status_t                  out_st_r, out_st_nxt;

  // Combinational helpers
  logic                     res_valid;
  logic [SYMBOL_OUT_W-1:0]  res_sym;
  status_t                  res_st;
  logic                     out_free;
  logic [LEN_W-1:0]         len_sat;
  logic [MAX_CODE_BITS-1:0] code_ext;
  logic                     ins_dir;
  logic [IDX_W-1:0]         ins_kid;
  logic [IDX_W-1:0]         dec_kid;
  logic                     store_full;

  assign out_free   = !out_valid_r || out_tready;
  assign len_sat    = (32'(in_code_len) > MAX_CODE_BITS) ? LEN_W'(MAX_CODE_BITS)
                                                         : LEN_W'(in_code_len);
  assign code_ext   = MAX_CODE_BITS'(in_code_word);
  assign ins_dir    = word_r[MAX_CODE_BITS-1];
  assign ins_kid    = ins_dir ? ent_k1_r : ent_k0_r;
  assign store_full = (used_r >= USED_W'(NODE_COUNT));
  assign dec_kid    = (walker_r == '0) ? (in_code_bit ? root1_r : root0_r)
                                       : (in_code_bit ? wk1_r : wk0_r);

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    used_nxt     = used_r;
    walker_nxt   = walker_r;
    root0_nxt    = root0_r;
    root1_nxt    = root1_r;
    cur_nxt      = cur_r;
    ent_k0_nxt   = ent_k0_r;
    ent_k1_nxt   = ent_k1_r;
    ent_leaf_nxt = ent_leaf_r;
    ent_sym_nxt  = ent_sym_r;
    len_nxt      = len_r;
    word_nxt     = word_r;
    sym_in_nxt   = sym_in_r;
    dir_nxt      = dir_r;
    new_nxt      = new_r;
    wk0_nxt      = wk0_r;
    wk1_nxt      = wk1_r;
    res_sym_nxt  = res_sym_r;
    res_st_nxt   = res_st_r;
    out_sym_nxt  = out_sym_r;
    out_st_nxt   = out_st_r;
    mem_we       = 1'b0;
    mem_waddr    = cur_r;
    mem_wdata    = '0;
    mem_raddr    = '0;
    res_valid    = 1'b0;
    res_sym      = '0;
    res_st       = ST_INSERTED;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_req == REQ_INSERT) begin
            // Start the walk at the root with the code bits left-aligned
            cur_nxt      = '0;
            ent_k0_nxt   = root0_r;
            ent_k1_nxt   = root1_r;
            ent_leaf_nxt = 1'b0;
            ent_sym_nxt  = '0;
            len_nxt      = len_sat;
            word_nxt     = code_ext << (LEN_W'(MAX_CODE_BITS) - len_sat);
            sym_in_nxt   = SYMBOL_BITS'(in_symbol);
            walker_nxt   = '0;
            state_nxt    = S_EVAL;
          end else if (dec_kid == '0) begin
            // No branch: flag it and rewind
            walker_nxt = '0;
            res_valid  = 1'b1;
            res_st     = ST_MISSING;
          end else begin
            // Fetch the child to test for a leaf
            mem_raddr = dec_kid;
            cur_nxt   = dec_kid;
            state_nxt = S_DRD;
          end
        end
      end

      S_EVAL: begin
        state_nxt = S_IDLE;
        if (len_r == '0) begin
          // Mark the final node; the root leaf flag is never read
          if (cur_r != '0) begin
            mem_we    = 1'b1;
            mem_waddr = cur_r;
            mem_wdata = {sym_in_r, 1'b1, ent_k1_r, ent_k0_r};
          end
          res_valid = 1'b1;
          res_st    = ST_INSERTED;
        end else if (ins_kid != '0) begin
          // Existing branch: descend and fetch it
          cur_nxt   = ins_kid;
          len_nxt   = len_r - LEN_W'(1);
          word_nxt  = word_r << 1;
          mem_raddr = ins_kid;
          state_nxt = S_RD;
        end else if (store_full) begin
          res_valid = 1'b1;
          res_st    = ST_FULL;
        end else begin
          // Allocate and clear a new node, link it next cycle
          mem_we    = 1'b1;
          mem_waddr = used_r[IDX_W-1:0];
          mem_wdata = '0;
          new_nxt   = used_r[IDX_W-1:0];
          used_nxt  = used_r + USED_W'(1);
          dir_nxt   = ins_dir;
          state_nxt = S_LINK;
        end
      end

      S_LINK: begin
        // Point the parent at the new node
        if (cur_r == '0) begin
          if (dir_r) begin
            root1_nxt = new_r;
          end else begin
            root0_nxt = new_r;
          end
        end else begin
          mem_we    = 1'b1;
          mem_waddr = cur_r;
          mem_wdata = dir_r ? {ent_sym_r, ent_leaf_r, new_r, ent_k0_r}
                            : {ent_sym_r, ent_leaf_r, ent_k1_r, new_r};
        end
        cur_nxt      = new_r;
        ent_k0_nxt   = '0;
        ent_k1_nxt   = '0;
        ent_leaf_nxt = 1'b0;
        ent_sym_nxt  = '0;
        len_nxt      = len_r - LEN_W'(1);
        word_nxt     = word_r << 1;
        state_nxt    = S_EVAL;
      end

      S_RD: begin
        // Capture the fetched node
        ent_k0_nxt   = rd_k0;
        ent_k1_nxt   = rd_k1;
        ent_leaf_nxt = rd_leaf;
        ent_sym_nxt  = rd_sym;
        state_nxt    = S_EVAL;
      end

      S_DRD: begin
        state_nxt = S_IDLE;
        if (rd_leaf) begin
          walker_nxt = '0;
          res_valid  = 1'b1;
          res_sym    = SYMBOL_OUT_W'(rd_sym);
          res_st     = ST_DECODED;
        end else begin
          // Advance the walker and cache its children
          walker_nxt = cur_r;
          wk0_nxt    = rd_k0;
          wk1_nxt    = rd_k1;
        end
      end

      S_RES: begin
        if (out_free) begin
          out_sym_nxt = res_sym_r;
          out_st_nxt  = res_st_r;
          state_nxt   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Hand a new result to the output register, or hold it until free
    if (res_valid) begin
      if (out_free) begin
        out_sym_nxt = res_sym;
        out_st_nxt  = res_st;
      end else begin
        res_sym_nxt = res_sym;
        res_st_nxt  = res_st;
        state_nxt   = S_RES;
      end
    end
  end

  // Output register valid
  always_comb begin
    if ((res_valid && out_free) || (state_r == S_RES && out_free)) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= USED_W'(1);
      walker_r    <= '0;
      root0_r     <= '0;
      root1_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      walker_r    <= walker_nxt;
      root0_r     <= root0_nxt;
      root1_r     <= root1_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    ent_k0_r   <= ent_k0_nxt;
    ent_k1_r   <= ent_k1_nxt;
    ent_leaf_r <= ent_leaf_nxt;
    ent_sym_r  <= ent_sym_nxt;
    len_r      <= len_nxt;
    word_r     <= word_nxt;
    sym_in_r   <= sym_in_nxt;
    dir_r      <= dir_nxt;
    new_r      <= new_nxt;
    wk0_r      <= wk0_nxt;
    wk1_r      <= wk1_nxt;
    res_sym_r  <= res_sym_nxt;
    res_st_r   <= res_st_nxt;
    out_sym_r  <= out_sym_nxt;
    out_st_r   <= out_st_nxt;
  end

  // Node memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[mem_raddr];
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sym_r;
  assign out_tuser  = out_st_r;

  // Allocation never runs past the store
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_W'(NODE_COUNT))
    else $error("node allocation count exceeds store size");

  // The walker only rests on allocated nodes
  a_walker_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    USED_W'(walker_r) < used_r)
    else $error("decode walker points at an unallocated node");

  // The insert walk stays inside the allocated nodes
  a_cur_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL || state_r == S_LINK) |-> (USED_W'(cur_r) < used_r))
    else $error("insert walk left the allocated nodes");

  // A held result only waits while the output register is occupied
  a_res_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RES) |-> out_valid_r)
    else $error("result held although output register is free");

  // An allocation is always followed by the parent link
  a_alloc_link: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL && used_nxt != used_r) |=> (state_r == S_LINK))
    else $error("new node allocated without linking its parent");

endmodule

// ----- dv/huffman_tree_build_and_decode_test.sv -----
// Self-checking testbench for the code tree build and bit-serial decode block.
// Predicts every result from its own model of the node store; needs htbd_pkg
// and huffman_tree_build_and_decode.
`timescale 1ns / 100ps

module huffman_tree_build_and_decode_test
  import htbd_pkg::*;
();

  localparam int TREE_NODES    = 512;
  localparam int CODE_BITS_MAX = 16;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int TAIL_CYCLES   = 40;

  typedef struct packed {
    logic [1:0][8:0] kid;
    logic            leaf;
    logic [7:0]      sym;
  } tree_node_t;

  typedef struct packed {
    logic [SYMBOL_OUT_W-1:0] symbol;
    status_t                 status;
  } tree_result_t;

  typedef struct {
    logic [CODE_WORD_W-1:0] word;
    int unsigned            len;
  } code_entry_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [1:0]  out_tuser;

  // Predicted tree state
  tree_node_t  tree_mem [TREE_NODES];
  int unsigned nodes_alloc;
  logic [8:0]  walk_pos;

  tree_result_t expected_q [$];
  code_entry_t  known_codes [$];

  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned mismatches = 0;
  int unsigned status_seen [4];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;

  huffman_tree_build_and_decode u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Walk the predicted tree for one request; got is low when no result follows
  task automatic predict_tree_step(input logic req, input logic bitv,
                                   input logic [7:0] sym, input logic [15:0] word,
                                   input logic [4:0] len, output bit got,
                                   output tree_result_t res);
    int unsigned walk_len;
    logic [8:0]  cur;
    logic [8:0]  nxt;
    logic        dir;
    got = 1'b1;
    res.symbol = '0;
    if (req == REQ_INSERT) begin
      walk_pos = '0;
      cur = '0;
      walk_len = (len > CODE_BITS_MAX) ? CODE_BITS_MAX : len;
      res.status = ST_INSERTED;
      for (int i = walk_len; i > 0; i--) begin
        dir = word[i-1];
        nxt = tree_mem[cur].kid[dir];
        if (nxt == '0) begin
          // out of nodes: stop here, keep what this insert already linked
          if (nodes_alloc >= TREE_NODES) begin
            res.status = ST_FULL;
            return;
          end
          nxt = nodes_alloc[8:0];
          nodes_alloc++;
          tree_mem[nxt] = '0;
          tree_mem[cur].kid[dir] = nxt;
        end
        cur = nxt;
      end
      tree_mem[cur].leaf = 1'b1;
      tree_mem[cur].sym = sym;
    end else begin
      nxt = tree_mem[walk_pos].kid[bitv];
      if (nxt == '0) begin
        walk_pos = '0;
        res.status = ST_MISSING;
      end else if (tree_mem[nxt].leaf) begin
        walk_pos = '0;
        res.symbol = tree_mem[nxt].sym;
        res.status = ST_DECODED;
      end else begin
        walk_pos = nxt;
        got = 1'b0;
      end
    end
  endtask

  // Offer one request, wait for its transfer, then record the prediction
  task automatic send_req(input logic req, input logic bitv, input logic [7:0] sym,
                          input logic [15:0] word, input logic [4:0] len);
    bit           got;
    tree_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {2'b00, len, word, sym, bitv};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    predict_tree_step(req, bitv, sym, word, len, got, res);
    if (got) expected_q.push_back(res);
    if (req == REQ_INSERT && res.status == ST_INSERTED && len != 0)
      known_codes.push_back('{word, (len > CODE_BITS_MAX) ? CODE_BITS_MAX : len});
  endtask

  task automatic send_insert(input logic [7:0] sym, input logic [15:0] word,
                             input logic [4:0] len);
    send_req(REQ_INSERT, 1'($urandom), sym, word, len);
  endtask

  task automatic send_decode(input logic bitv);
    send_req(REQ_DECODE, bitv, 8'($urandom), 16'($urandom), 5'($urandom));
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Insert a fresh code, or re-mark a stored code or one of its prefixes
  task automatic send_random_insert();
    logic [15:0] word;
    logic [4:0]  len;
    int unsigned r;
    int unsigned pick;
    int unsigned cut;
    word = 16'($urandom);
    r = $urandom_range(99);
    if (r < 35 && known_codes.size() > 0) begin
      pick = $urandom_range(known_codes.size() - 1);
      cut = $urandom_range(known_codes[pick].len - 1);
      word = known_codes[pick].word >> cut;
      len = 5'(known_codes[pick].len - cut);
    end else if (r < 80) begin
      len = 5'($urandom_range(8, 1));
    end else if (r < 92) begin
      len = 5'($urandom_range(16, 9));
    end else if (r < 97) begin
      len = 5'($urandom_range(31, 17));
    end else begin
      len = '0;
    end
    send_insert(8'($urandom), word, len);
  endtask

  // Feed the bits of a stored code, now and then with one bit flipped
  task automatic send_code_bits();
    code_entry_t c;
    bit          broken;
    int          flip;
    logic        bitv;
    c = known_codes[$urandom_range(known_codes.size() - 1)];
    broken = ($urandom_range(9) == 0);
    flip = $urandom_range(c.len - 1);
    for (int pos = int'(c.len) - 1; pos >= 0; pos--) begin
      bitv = c.word[pos];
      if (broken && pos == flip) bitv = ~bitv;
      send_decode(bitv);
    end
  endtask

  task automatic random_traffic(input int unsigned n);
    int unsigned target;
    int unsigned r;
    target = items_sent + n;
    while (items_sent < target) begin
      r = $urandom_range(99);
      if (r < 25) send_random_insert();
      else if (r < 88 && known_codes.size() > 0) send_code_bits();
      else send_decode(1'($urandom));
    end
  endtask

  // Small hand-built tree: 0, 10, 110, then long, saturated and empty codes
  task automatic test_directed();
    set_idling(0, 0);
    send_decode(1'b0);
    send_decode(1'b1);
    send_insert(8'h00, 16'h0000, 5'd1);
    send_insert(8'hFF, 16'h0002, 5'd2);
    send_insert(8'hA5, 16'h0006, 5'd3);
    send_decode(1'b0);
    send_decode(1'b1);
    send_decode(1'b0);
    send_decode(1'b1);
    send_decode(1'b1);
    send_decode(1'b0);
    // missing right branch below node 11
    send_decode(1'b1);
    send_decode(1'b1);
    send_decode(1'b1);
    // walker parked on an inner node, then sent home by an insert
    send_decode(1'b1);
    send_insert(8'h3C, 16'hFFFF, 5'd0);
    send_decode(1'b0);
    send_insert(8'h81, 16'h0000, 5'd1);
    send_decode(1'b0);
    send_insert(8'h5A, 16'hFFFF, 5'd16);
    send_insert(8'hC3, 16'h0001, 5'd31);
    send_insert(8'h7E, 16'hFFFF, 5'd20);
    // leaf with children below it still ends the walk
    send_decode(1'b0);
    send_insert(8'h99, 16'h0001, 5'd1);
    send_decode(1'b1);
  endtask

  task automatic test_random_free();
    set_idling(0, 0);
    random_traffic(400);
  endtask

  task automatic test_random_sender_idle();
    set_idling(62, 0);
    random_traffic(400);
  endtask

  // Long random codes until the node store runs dry
  task automatic test_store_full();
    set_idling(15, 15);
    repeat (40) send_insert(8'($urandom), 16'($urandom), 5'd16);
  endtask

  task automatic test_random_receiver_stall();
    set_idling(0, 62);
    random_traffic(400);
  endtask

  task automatic test_random_both_idle();
    set_idling(15, 15);
    random_traffic(400);
  endtask

  // Hold the result side off while inserts keep coming, so the input stalls
  task automatic test_output_backpressure();
    set_idling(0, 0);
    hold_req = 300;
    repeat (30) send_random_insert();
    random_traffic(20);
  endtask

  // Check each result transfer and drive out_tready for the next cycle
  always @(posedge clk) begin
    tree_result_t exp_res;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_q.size());
      $display("huffman_tree_build_and_decode_test: done, errors");
      $finish;
    end else begin
      cycle_count++;
      if (rst_n && out_tvalid && out_tready) begin
        status_seen[out_tuser]++;
        if (expected_q.size() == 0) begin
          $error("unexpected result: symbol_out %0h status %0d", out_tdata, out_tuser);
          mismatches++;
        end else begin
          exp_res = expected_q.pop_front();
          if (out_tdata !== exp_res.symbol) begin
            $error("symbol_out: expected %0h, got %0h", exp_res.symbol, out_tdata);
            mismatches++;
          end
          if (out_tuser !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, out_tuser);
            mismatches++;
          end
        end
      end
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    for (int i = 0; i < TREE_NODES; i++) tree_mem[i] = '0;
    nodes_alloc = 1;
    walk_pos = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_free();
    test_random_sender_idle();
    test_store_full();
    test_random_receiver_stall();
    test_random_both_idle();
    test_output_backpressure();

    // Drain the result side, then leave room for a stray late result
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d requests over idle, stall and long-hold phases; %0d of %0d nodes used",
             items_sent, nodes_alloc, TREE_NODES);
    $display("results seen: decoded %0d, inserted %0d, store full %0d, missing branch %0d",
             status_seen[ST_DECODED], status_seen[ST_INSERTED],
             status_seen[ST_FULL], status_seen[ST_MISSING]);
    if (mismatches == 0)
      $display("huffman_tree_build_and_decode_test: done, clean");
    else
      $display("huffman_tree_build_and_decode_test: done, errors");
    $finish;
  end

endmodule
